[design/sledpg_pkg.sv]
// ----------------------------------------------------------------------------
// Status LED pattern generator - shared package
// Status codes, register indexes, blink tables and the sequencer microcode.
// ----------------------------------------------------------------------------
package sledpg_pkg;

   typedef logic [2:0]  status_type;
   typedef logic [1:0]  csr_index_type;
   typedef logic [15:0] csr_data_type;
   typedef logic [3:0]  pc_type;
   typedef logic [9:0]  blink_ms_type;

   localparam status_type STATUS_BOOT      = 3'd0;
   localparam status_type STATUS_WIFI      = 3'd1;
   localparam status_type STATUS_WARMUP    = 3'd2;
   localparam status_type STATUS_STREAMING = 3'd3;
   localparam status_type STATUS_NET_LOST  = 3'd4;
   localparam status_type STATUS_ERROR     = 3'd5;

   localparam csr_index_type CSR_BREATH_PERIOD   = 2'd0;
   localparam csr_index_type CSR_BREATH_GAMMA    = 2'd1;
   localparam csr_index_type CSR_DUTY_FULL_SCALE = 2'd2;

   localparam logic [15:0] BREATH_PERIOD_RESET   = 16'd4000;
   localparam logic [2:0]  BREATH_GAMMA_RESET    = 3'd2;
   localparam logic [15:0] DUTY_FULL_SCALE_RESET = 16'd8191;

   // restoring divider: 32-bit dividend, 16-bit divisor
   localparam int DIV_STEPS = 32;
   localparam int DIV_COUNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_COUNT_W-1:0] DIV_LAST = DIV_COUNT_W'(DIV_STEPS - 1);

   // cosine series, Q28
   localparam int COS_TERMS = 14;
   localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;
   localparam longint unsigned Q28_ONE = 64'd1 << 28;
   localparam longint unsigned COS_DIVISOR [COS_TERMS-1] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
      64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650
   };

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_BLINK,
      OP_DIV_ELAPSED,
      OP_DIV_SCALE,
      OP_DIV_STEP,
      OP_LOOKUP,
      OP_GAMMA_INIT,
      OP_GAMMA,
      OP_DUTY,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_STREAM,
      COND_OUT_BUSY,
      COND_DIV_MORE,
      COND_GAMMA_DONE,
      COND_GAMMA_MORE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type wait_cond;
      cond_type jump_cond;
      pc_type   target;
   } ctrl_word_type;

   localparam pc_type STEP_LOAD        = 4'd0;
   localparam pc_type STEP_BLINK       = 4'd1;
   localparam pc_type STEP_EMIT        = 4'd2;
   localparam pc_type STEP_ELAPSED     = 4'd3;
   localparam pc_type STEP_MOD_LOOP    = 4'd4;
   localparam pc_type STEP_SCALE       = 4'd5;
   localparam pc_type STEP_INDEX_LOOP  = 4'd6;
   localparam pc_type STEP_LOOKUP      = 4'd7;
   localparam pc_type STEP_GAMMA_INIT  = 4'd8;
   localparam pc_type STEP_GAMMA_LOOP  = 4'd9;
   localparam pc_type STEP_DUTY        = 4'd10;

   // microcode: stall on wait_cond, else jump on jump_cond, else fall through
   function automatic ctrl_word_type microcode(input pc_type pc);
      ctrl_word_type w;
      case (pc)
         STEP_LOAD:       w = '{OP_LOAD,        COND_NO_REQ,   COND_STREAM,     STEP_ELAPSED};
         STEP_BLINK:      w = '{OP_BLINK,       COND_NEVER,    COND_NEVER,      STEP_LOAD};
         STEP_EMIT:       w = '{OP_EMIT,        COND_OUT_BUSY, COND_ALWAYS,     STEP_LOAD};
         STEP_ELAPSED:    w = '{OP_DIV_ELAPSED, COND_NEVER,    COND_NEVER,      STEP_LOAD};
         STEP_MOD_LOOP:   w = '{OP_DIV_STEP,    COND_NEVER,    COND_DIV_MORE,   STEP_MOD_LOOP};
         STEP_SCALE:      w = '{OP_DIV_SCALE,   COND_NEVER,    COND_NEVER,      STEP_LOAD};
         STEP_INDEX_LOOP: w = '{OP_DIV_STEP,    COND_NEVER,    COND_DIV_MORE,   STEP_INDEX_LOOP};
         STEP_LOOKUP:     w = '{OP_LOOKUP,      COND_NEVER,    COND_NEVER,      STEP_LOAD};
         STEP_GAMMA_INIT: w = '{OP_GAMMA_INIT,  COND_NEVER,    COND_GAMMA_DONE, STEP_DUTY};
         STEP_GAMMA_LOOP: w = '{OP_GAMMA,       COND_NEVER,    COND_GAMMA_MORE, STEP_GAMMA_LOOP};
         STEP_DUTY:       w = '{OP_DUTY,        COND_NEVER,    COND_ALWAYS,     STEP_EMIT};
         default:         w = '{OP_NOP,         COND_NEVER,    COND_ALWAYS,     STEP_LOAD};
      endcase
      return w;
   endfunction

   // on/off durations in ms; unknown codes fall back to the boot table
   function automatic blink_ms_type blink_duration(input status_type status,
                                                   input logic [1:0] step);
      blink_ms_type d;
      case (status)
         STATUS_WIFI:                    d = 10'd100;
         STATUS_WARMUP:                  d = 10'd250;
         STATUS_STREAMING, STATUS_ERROR: d = step[0] ? 10'd200 : 10'd800;
         STATUS_NET_LOST: begin
            case (step)
               2'd1:    d = 10'd120;
               2'd3:    d = 10'd760;
               default: d = 10'd60;
            endcase
         end
         default:                        d = 10'd50;
      endcase
      return d;
   endfunction

   function automatic logic [1:0] blink_next(input status_type status,
                                            input logic [1:0] step);
      logic [1:0] n;
      n = step + 2'd1;
      if (status != STATUS_NET_LOST) begin
         n = {1'b0, n[0]};
      end
      return n;
   endfunction

endpackage

[design/status_led_pattern_generator_core.sv]
// ----------------------------------------------------------------------------
// Status LED pattern generator core
// Microcoded sequencer that turns time samples into LED PWM duty words.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one word per time sample (req_now_ms, req_device_status).
//   rsp_*  : one word per sample (rsp_duty, rsp_pattern_index), in order.
//   csr_*  : register writes, always ready; index 0 breath period, 1 gamma,
//            2 duty full scale. Write only while no sample is in flight.
// Timing:
//   Blink statuses go through the load, blink and emit steps; the next sample
//   is taken only once the word has been handed to the output register.
//   Streaming (breathing) goes through two 32-step passes of the shared
//   restoring divider (phase, then table index), the table lookup, one gamma
//   multiply per power above the first (gamma 0 counts as 1), the duty
//   scale and the emit step.
// Reset:
//   Registers return to their defaults, the pattern state clears to boot,
//   and the sequencer waits for a sample.
// Stall:
//   A finished word sits in the output register; the next sample is still
//   accepted and worked on, and only its hand-off waits for rsp_ready.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_core #(
   parameter int COSINE_TABLE_DEPTH  = 256,
   parameter int LEVEL_FRACTION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [31:0]               req_now_ms,
   input  sledpg_pkg::status_type    req_device_status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [15:0]               rsp_duty,
   output logic [1:0]                rsp_pattern_index,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  sledpg_pkg::csr_index_type csr_index,
   input  sledpg_pkg::csr_data_type  csr_wdata
);
   import sledpg_pkg::*;

   localparam int F        = LEVEL_FRACTION_BITS;
   localparam int LW       = F + 1;
   localparam int PW       = 2 * LW;
   localparam int DW       = LW + 17;
   localparam int HALF     = COSINE_TABLE_DEPTH / 2;
   localparam int ROM_SIZE = HALF + 1;
   localparam int IW       = $clog2(COSINE_TABLE_DEPTH);
   localparam int JW       = $clog2(ROM_SIZE);
   localparam longint unsigned ROUND_LSB = 64'd1 << (27 - F);
   localparam int HALF_LSB = 2 ** (F - 1);

   // breathing level for table index j, rounded to F fraction bits
   function automatic logic [LW-1:0] level_calc(input int unsigned j);
      longint unsigned jj, theta, x2, term, lvl28;
      longint sum;
      jj = 64'(j);
      theta = (jj * TWO_PI_Q28 + 64'(COSINE_TABLE_DEPTH / 2)) / 64'(COSINE_TABLE_DEPTH);
      x2 = (theta * theta) >> 28;
      term = Q28_ONE;
      sum = longint'(Q28_ONE);
      for (int k = 1; k < COS_TERMS; k++) begin
         term = ((term * x2) >> 28) / COS_DIVISOR[k-1];
         if (k[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum > longint'(Q28_ONE)) begin
         sum = longint'(Q28_ONE);
      end
      if (sum < -longint'(Q28_ONE)) begin
         sum = -longint'(Q28_ONE);
      end
      lvl28 = unsigned'(longint'(Q28_ONE) - sum) >> 1;
      return LW'((lvl28 + ROUND_LSB) >> (28 - F));
   endfunction

   logic [LW-1:0] level_rom [ROM_SIZE];

   for (genvar g = 0; g < ROM_SIZE; g++) begin : gen_level_rom
      assign level_rom[g] = level_calc(g);
   end

   // sequencer
   pc_type                 pc_ff, pc_in;
   ctrl_word_type          ctrl;
   logic                   wait_hit, jump_hit;

   // item and pattern state
   logic [31:0]            now_ff, now_in;
   status_type             last_status_ff, last_status_in;
   logic [1:0]             step_index_ff, step_index_in;
   logic [31:0]            step_begin_ff, step_begin_in;
   logic [31:0]            breath_begin_ff, breath_begin_in;

   // configuration
   logic [15:0]            period_ff, period_in;
   logic [2:0]             gamma_ff, gamma_in;
   logic [15:0]            full_scale_ff, full_scale_in;

   // datapath
   logic [31:0]            dvd_ff, dvd_in;
   logic [15:0]            rem_ff, rem_in;
   logic [DIV_COUNT_W-1:0] div_count_ff, div_count_in;
   logic [LW-1:0]          level_ff, level_in;
   logic [LW-1:0]          g_ff, g_in;
   logic [2:0]             gamma_count_ff, gamma_count_in;
   logic [15:0]            res_duty_ff, res_duty_in;
   logic [1:0]             res_pattern_ff, res_pattern_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_duty_ff, rsp_duty_in;
   logic [1:0]             rsp_pattern_ff, rsp_pattern_in;

   logic [15:0]            period_eff;
   logic [2:0]             gamma_eff;
   logic [16:0]            trial;
   logic                   trial_ge;
   logic [IW-1:0]          idx;
   logic [IW:0]            j_wide;
   logic [31:0]            blink_elapsed;
   logic [1:0]             blink_step;
   logic [PW-1:0]          gamma_prod;
   logic [DW-1:0]          duty_prod;

   assign ctrl      = microcode(pc_ff);
   assign req_ready = (ctrl.op == OP_LOAD);
   assign csr_ready = 1'b1;

   assign period_eff = (period_ff == 16'd0) ? 16'd1 : period_ff;
   assign gamma_eff  = (gamma_ff == 3'd0) ? 3'd1 : gamma_ff;

   function automatic logic cond_eval(input cond_type c,
                                      input logic req_v,
                                      input logic stream,
                                      input logic out_busy,
                                      input logic div_more,
                                      input logic gamma_done,
                                      input logic gamma_more);
      logic r;
      case (c)
         COND_NEVER:      r = 1'b0;
         COND_ALWAYS:     r = 1'b1;
         COND_NO_REQ:     r = !req_v;
         COND_STREAM:     r = stream;
         COND_OUT_BUSY:   r = out_busy;
         COND_DIV_MORE:   r = div_more;
         COND_GAMMA_DONE: r = gamma_done;
         COND_GAMMA_MORE: r = gamma_more;
         default:         r = 1'b0;
      endcase
      return r;
   endfunction

   logic c_stream, c_out_busy, c_div_more, c_gamma_done, c_gamma_more;

   assign c_stream     = (req_device_status == STATUS_STREAMING);
   assign c_out_busy   = rsp_valid_ff && !rsp_ready;
   assign c_div_more   = (div_count_ff != DIV_LAST);
   // skip the multiply loop when the level is used as is
   assign c_gamma_done = (gamma_eff == 3'd1);
   assign c_gamma_more = ({1'b0, gamma_count_ff} + 4'd1 < {1'b0, gamma_eff});

   assign wait_hit = cond_eval(ctrl.wait_cond, req_valid, c_stream, c_out_busy,
                               c_div_more, c_gamma_done, c_gamma_more);
   assign jump_hit = cond_eval(ctrl.jump_cond, req_valid, c_stream, c_out_busy,
                               c_div_more, c_gamma_done, c_gamma_more);

   always_comb begin
      if (wait_hit) begin
         pc_in = pc_ff;
      end else if (jump_hit) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   // datapath helpers
   assign trial    = {rem_ff, dvd_ff[31]};
   assign trial_ge = (trial >= {1'b0, period_eff});
   assign idx      = dvd_ff[IW-1:0];
   assign j_wide   = ({1'b0, idx} > (IW+1)'(HALF)) ?
                     (IW+1)'(COSINE_TABLE_DEPTH) - {1'b0, idx} : {1'b0, idx};

   assign blink_elapsed = now_ff - step_begin_ff;
   assign blink_step    = (blink_elapsed >= {22'd0, blink_duration(last_status_ff,
                                                                    step_index_ff)})
                          ? blink_next(last_status_ff, step_index_ff) : step_index_ff;

   assign gamma_prod = PW'(g_ff) * PW'(level_ff) + PW'(HALF_LSB);
   assign duty_prod  = DW'(g_ff) * DW'(full_scale_ff) + DW'(HALF_LSB);

   always_comb begin
      now_in          = now_ff;
      last_status_in  = last_status_ff;
      step_index_in   = step_index_ff;
      step_begin_in   = step_begin_ff;
      breath_begin_in = breath_begin_ff;
      period_in       = period_ff;
      gamma_in        = gamma_ff;
      full_scale_in   = full_scale_ff;
      dvd_in          = dvd_ff;
      rem_in          = rem_ff;
      div_count_in    = div_count_ff;
      level_in        = level_ff;
      g_in            = g_ff;
      gamma_count_in  = gamma_count_ff;
      res_duty_in     = res_duty_ff;
      res_pattern_in  = res_pattern_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_duty_in     = rsp_duty_ff;
      rsp_pattern_in  = rsp_pattern_ff;

      if (!wait_hit) begin
         case (ctrl.op)
            OP_LOAD: begin
               now_in = req_now_ms;
               // restart the pattern on a status change
               if (req_device_status != last_status_ff) begin
                  last_status_in  = req_device_status;
                  step_index_in   = 2'd0;
                  step_begin_in   = req_now_ms;
                  breath_begin_in = req_now_ms;
               end
            end
            OP_BLINK: begin
               if (blink_step != step_index_ff ||
                   blink_elapsed >= {22'd0, blink_duration(last_status_ff,
                                                           step_index_ff)}) begin
                  step_begin_in = now_ff;
               end
               step_index_in  = blink_step;
               res_duty_in    = blink_step[0] ? 16'd0 : full_scale_ff;
               res_pattern_in = blink_step;
            end
            OP_DIV_ELAPSED: begin
               dvd_in       = now_ff - breath_begin_ff;
               rem_in       = 16'd0;
               div_count_in = '0;
            end
            OP_DIV_SCALE: begin
               dvd_in       = 32'(rem_ff) * 32'(COSINE_TABLE_DEPTH);
               rem_in       = 16'd0;
               div_count_in = '0;
            end
            OP_DIV_STEP: begin
               rem_in       = trial_ge ? 16'(trial - {1'b0, period_eff}) : trial[15:0];
               dvd_in       = {dvd_ff[30:0], trial_ge};
               div_count_in = div_count_ff + 1'b1;
            end
            OP_LOOKUP: begin
               level_in = level_rom[j_wide[JW-1:0]];
            end
            OP_GAMMA_INIT: begin
               g_in           = level_ff;
               gamma_count_in = 3'd1;
            end
            OP_GAMMA: begin
               g_in           = LW'(gamma_prod >> F);
               gamma_count_in = gamma_count_ff + 3'd1;
            end
            OP_DUTY: begin
               res_duty_in    = duty_prod[F+15:F];
               res_pattern_in = step_index_ff;
            end
            OP_EMIT: begin
               rsp_valid_in   = 1'b1;
               rsp_duty_in    = res_duty_ff;
               rsp_pattern_in = res_pattern_ff;
            end
            default: begin
            end
         endcase
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_BREATH_PERIOD:   period_in     = csr_wdata;
            CSR_BREATH_GAMMA:    gamma_in      = csr_wdata[2:0];
            CSR_DUTY_FULL_SCALE: full_scale_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff           <= STEP_LOAD;
         last_status_ff  <= STATUS_BOOT;
         step_index_ff   <= 2'd0;
         step_begin_ff   <= 32'd0;
         breath_begin_ff <= 32'd0;
         period_ff       <= BREATH_PERIOD_RESET;
         gamma_ff        <= BREATH_GAMMA_RESET;
         full_scale_ff   <= DUTY_FULL_SCALE_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pc_ff           <= pc_in;
         last_status_ff  <= last_status_in;
         step_index_ff   <= step_index_in;
         step_begin_ff   <= step_begin_in;
         breath_begin_ff <= breath_begin_in;
         period_ff       <= period_in;
         gamma_ff        <= gamma_in;
         full_scale_ff   <= full_scale_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      dvd_ff         <= dvd_in;
      rem_ff         <= rem_in;
      div_count_ff   <= div_count_in;
      level_ff       <= level_in;
      g_ff           <= g_in;
      gamma_count_ff <= gamma_count_in;
      res_duty_ff    <= res_duty_in;
      res_pattern_ff <= res_pattern_in;
      rsp_duty_ff    <= rsp_duty_in;
      rsp_pattern_ff <= rsp_pattern_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty          = rsp_duty_ff;
   assign rsp_pattern_index = rsp_pattern_ff;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Status LED pattern generator - testbench
// Sends time samples with blink and breathing statuses through the core
// under several register settings, random idle bursts on both channels, and
// checks every duty word against an in-bench model of the pattern state.
// ----------------------------------------------------------------------------
module tb;
   import sledpg_pkg::*;

   localparam int COS_DEPTH    = 256;
   localparam int LEVEL_BITS   = 16;
   localparam int QUIET_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 10;

   // codes past the last defined status fall back to the boot table
   localparam status_type STATUS_SPARE_6 = 3'd6;
   localparam status_type STATUS_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [31:0] now_ms;
      status_type  status;
   } led_sample_type;

   typedef struct packed {
      logic [31:0] now_ms;
      status_type  status;
      logic [15:0] duty;
      logic [1:0]  pattern;
   } led_word_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [31:0]   req_now_ms = '0;
   status_type    req_device_status = STATUS_BOOT;
   logic          rsp_valid;
   logic          rsp_ready = 1'b1;
   logic [15:0]   rsp_duty;
   logic [1:0]    rsp_pattern_index;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_BREATH_PERIOD;
   csr_data_type  csr_wdata = '0;

   led_sample_type sample_queue[$];
   led_word_type   led_word_expect[$];
   led_sample_type next_sample;
   led_word_type   want_word;
   logic        req_taken = 1'b0;
   logic        idle_enable = 1'b1;
   int          req_gap = 0;
   int          rsp_hold = 0;
   int          quiet_cycles = 0;
   int          mismatch_count = 0;
   logic [31:0] sample_clock = '0;
   status_type  sample_status = STATUS_BOOT;

   // model state and register copies
   status_type  led_status;
   logic [1:0]  led_step;
   logic [31:0] led_step_begin;
   logic [31:0] led_breath_begin;
   logic [15:0] cfg_period;
   logic [2:0]  cfg_gamma;
   logic [15:0] cfg_full_scale;

   status_led_pattern_generator_core #(
      .COSINE_TABLE_DEPTH  (COS_DEPTH),
      .LEVEL_FRACTION_BITS (LEVEL_BITS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_now_ms        (req_now_ms),
      .req_device_status (req_device_status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_duty          (rsp_duty),
      .rsp_pattern_index (rsp_pattern_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // (1 - cos)/2 in Q28 for one table slot, cosine by truncated Taylor series
   function automatic longint unsigned breath_level_q28(input longint unsigned idx);
      longint unsigned depth;
      longint unsigned j;
      longint unsigned theta;
      longint unsigned x2;
      longint unsigned term;
      longint          q28;
      longint          sum;
      depth = COS_DEPTH;
      q28   = longint'(Q28_ONE);
      j     = (idx > depth / 2) ? depth - idx : idx;
      theta = (j * TWO_PI_Q28 + depth / 2) / depth;
      x2    = (theta * theta) >> 28;
      term  = Q28_ONE;
      sum   = q28;
      for (int k = 1; k < COS_TERMS; k++) begin
         term = ((term * x2) >> 28) / longint'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum > q28) sum = q28;
      if (sum < -q28) sum = -q28;
      return longint'(q28 - sum) >> 1;
   endfunction

   function automatic logic [15:0] breath_duty(input logic [31:0] elapsed);
      longint unsigned period;
      longint unsigned phase;
      longint unsigned idx;
      longint unsigned level;
      longint unsigned powered;
      longint unsigned scaled;
      longint unsigned half;
      int              powers;
      half    = 64'd1 << (LEVEL_BITS - 1);
      period  = (cfg_period == 16'd0) ? 64'd1 : 64'(cfg_period);
      phase   = 64'(elapsed) % period;
      idx     = phase * COS_DEPTH / period;
      level   = (breath_level_q28(idx) + (64'd1 << (27 - LEVEL_BITS))) >> (28 - LEVEL_BITS);
      powered = level;
      powers  = (cfg_gamma == 3'd0) ? 1 : int'(cfg_gamma);
      for (int i = 1; i < powers; i++) begin
         powered = (powered * level + half) >> LEVEL_BITS;
      end
      scaled = (powered * 64'(cfg_full_scale) + half) >> LEVEL_BITS;
      return scaled[15:0];
   endfunction

   function automatic int unsigned blink_ms(input status_type status, input logic [1:0] step);
      case (status)
         STATUS_WIFI:     return 100;
         STATUS_WARMUP:   return 250;
         STATUS_ERROR:    return step[0] ? 200 : 800;
         STATUS_NET_LOST: return (step == 2'd1) ? 120 : ((step == 2'd3) ? 760 : 60);
         default:         return 50;
      endcase
   endfunction

   // advance the pattern state by one sample and return the duty word it gives
   function automatic led_word_type predict_led_word(input logic [31:0] now,
                                                     input status_type status);
      led_word_type w;
      logic [31:0]  since;
      w.now_ms = now;
      w.status = status;
      if (status != led_status) begin
         led_status       = status;
         led_step         = 2'd0;
         led_step_begin   = now;
         led_breath_begin = now;
      end
      if (status == STATUS_STREAMING) begin
         w.duty = breath_duty(now - led_breath_begin);
      end else begin
         since = now - led_step_begin;
         if (since >= blink_ms(status, led_step)) begin
            led_step_begin = now;
            led_step = (status == STATUS_NET_LOST) ? led_step + 2'd1 : {1'b0, ~led_step[0]};
         end
         w.duty = led_step[0] ? 16'd0 : cfg_full_scale;
      end
      w.pattern = led_step;
      return w;
   endfunction

   // sample driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            next_sample = sample_queue.pop_front();
            req_valid         <= 1'b1;
            req_now_ms        <= next_sample.now_ms;
            req_device_status <= next_sample.status;
            if (idle_enable && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // random result back-pressure bursts
   always @(negedge clock) begin
      if (reset || !idle_enable) begin
         rsp_hold = 0;
         rsp_ready <= 1'b1;
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_hold = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      if (reset) begin
         led_status       = STATUS_BOOT;
         led_step         = 2'd0;
         led_step_begin   = '0;
         led_breath_begin = '0;
         cfg_period       = BREATH_PERIOD_RESET;
         cfg_gamma        = BREATH_GAMMA_RESET;
         cfg_full_scale   = DUTY_FULL_SCALE_RESET;
         quiet_cycles     = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (led_word_expect.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("unexpected word: duty %0d pattern %0d",
                           rsp_duty, rsp_pattern_index);
               end
               mismatch_count++;
            end else begin
               want_word = led_word_expect.pop_front();
               if (rsp_duty !== want_word.duty || rsp_pattern_index !== want_word.pattern) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display({"mismatch now_ms %h status %0d: expected duty %0d ",
                               "pattern %0d, got duty %0d pattern %0d"},
                              want_word.now_ms, want_word.status, want_word.duty,
                              want_word.pattern, rsp_duty, rsp_pattern_index);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            led_word_expect.push_back(predict_led_word(req_now_ms, req_device_status));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BREATH_PERIOD:   cfg_period = csr_wdata;
               CSR_BREATH_GAMMA:    cfg_gamma = csr_wdata[2:0];
               CSR_DUTY_FULL_SCALE: cfg_full_scale = csr_wdata;
               default: ;
            endcase
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic write_register(input csr_index_type idx, input csr_data_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [15:0] period, input logic [2:0] gamma,
                                 input logic [15:0] full_scale);
      write_register(CSR_BREATH_PERIOD, period);
      // upper bits of the gamma word are don't-care; drive junk there
      write_register(CSR_BREATH_GAMMA, {13'($urandom), gamma});
      write_register(CSR_DUTY_FULL_SCALE, full_scale);
   endtask

   task automatic push_sample(input logic [31:0] now, input status_type status);
      sample_queue.push_back('{now_ms: now, status: status});
   endtask

   // hold off until the core has drained every sample
   task automatic wait_drained();
      while (sample_queue.size() != 0 || req_valid || led_word_expect.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // mostly steady statuses with small time steps, plus jumps and status flips
   task automatic run_random(input int count);
      int r;
      @(posedge clock);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            sample_status = ($urandom_range(0, 2) == 0) ? STATUS_STREAMING
                                                        : status_type'($urandom_range(0, 7));
         end
         r = $urandom_range(0, 99);
         if (r < 3) begin
            sample_clock = $urandom;
         end else if (r < 15) begin
            sample_clock = sample_clock + $urandom_range(0, 2000);
         end else begin
            sample_clock = sample_clock + $urandom_range(0, 300);
         end
         push_sample(sample_clock, sample_status);
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // walk each blink table, breathing phases, spare codes and timestamp wrap
      @(posedge clock);
      push_sample(32'd0,    STATUS_BOOT);
      push_sample(32'd49,   STATUS_BOOT);
      push_sample(32'd50,   STATUS_BOOT);
      push_sample(32'd100,  STATUS_BOOT);
      push_sample(32'd100,  STATUS_WIFI);
      push_sample(32'd200,  STATUS_WIFI);
      push_sample(32'd300,  STATUS_WARMUP);
      push_sample(32'd550,  STATUS_WARMUP);
      push_sample(32'd1000, STATUS_NET_LOST);
      push_sample(32'd1060, STATUS_NET_LOST);
      push_sample(32'd1180, STATUS_NET_LOST);
      push_sample(32'd1240, STATUS_NET_LOST);
      push_sample(32'd2000, STATUS_NET_LOST);
      push_sample(32'd3000, STATUS_ERROR);
      push_sample(32'd3800, STATUS_ERROR);
      push_sample(32'd5000, STATUS_STREAMING);
      push_sample(32'd6000, STATUS_STREAMING);
      push_sample(32'd7000, STATUS_STREAMING);
      push_sample(32'd8999, STATUS_STREAMING);
      push_sample(32'd9000, STATUS_SPARE_6);
      push_sample(32'd9050, STATUS_SPARE_6);
      push_sample(32'd9100, STATUS_SPARE_7);
      push_sample(32'hFFFF_FFF0, STATUS_BOOT);
      push_sample(32'h0000_0030, STATUS_BOOT);
      push_sample(32'hFFFF_FFFF, STATUS_STREAMING);
      wait_drained();

      sample_clock  = $urandom;
      sample_status = STATUS_STREAMING;

      apply_settings(16'd1, 3'd1, 16'hFFFF);
      run_random(140);
      apply_settings(16'hFFFF, 3'd4, 16'd1);
      run_random(140);
      apply_settings(16'd0, 3'd0, 16'd0);
      run_random(60);
      apply_settings(16'($urandom_range(2, 1000)), 3'd7, 16'($urandom));
      run_random(140);
      apply_settings(16'($urandom_range(1000, 8000)), 3'd5, 16'($urandom));
      run_random(120);
      apply_settings(16'($urandom_range(1, 300)), 3'd6, 16'($urandom));
      run_random(120);
      apply_settings(16'($urandom), 3'($urandom_range(1, 4)), 16'($urandom));
      run_random(120);

      // quiet tail: no idling on either side
      apply_settings(BREATH_PERIOD_RESET, BREATH_GAMMA_RESET, DUTY_FULL_SCALE_RESET);
      @(posedge clock);
      idle_enable <= 1'b0;
      run_random(140);

      repeat (100) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
design/sledpg_pkg.sv
design/status_led_pattern_generator_core.sv
tb/tb.sv
